@@ hw/rtl/size_class_slab_allocator_macros.svh @@
`ifndef SIZE_CLASS_SLAB_ALLOCATOR_MACROS_SVH
`define SIZE_CLASS_SLAB_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled in reset
`define SCSA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SCSA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/scsa_pkg.sv @@
`timescale 1ns / 1ps
package scsa_pkg;

  // fixed geometry
  localparam int PAGE_BYTES      = 4096;
  localparam int PAGE_SHIFT      = 12;
  localparam int HEADER_BYTES    = 8;
  localparam int NUM_CLASSES     = 8;
  localparam int MIN_CLASS_BYTES = 32;
  localparam int MIN_SHIFT       = 5;
  localparam int MAX_REQUEST     = 4096;
  localparam int MAX_CLASS_BYTES = MIN_CLASS_BYTES << (NUM_CLASSES - 1);
  localparam int SLOTS_PER_PAGE  = PAGE_BYTES / MIN_CLASS_BYTES;
  localparam int SLOT_SHIFT      = PAGE_SHIFT - MIN_SHIFT;
  localparam int POOL_PAGES_DEF  = 64;

  localparam int CLS_W    = 3;
  localparam int TAG_W    = 4;
  localparam int TAG_LIVE = 3;
  localparam int CFG_IDX_W = 2;

  typedef logic [CLS_W-1:0] cls_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LIMIT = 2'd1;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_ZERO_SIZE = 3'd1,
    STAT_TOO_LARGE = 3'd2,
    STAT_NO_PAGE   = 3'd3,
    STAT_NULL_PTR  = 3'd4,
    STAT_BAD_PTR   = 3'd5
  } status_e;

  // decoded request flags
  typedef struct packed {
    cls_t cls;
    logic zero_size;
    logic too_large;
    logic null_ptr;
    logic located;
  } scsa_dec_t;

  function automatic logic [12:0] class_bytes(cls_t c);
    return 13'(MIN_CLASS_BYTES << c);
  endfunction

  function automatic logic [7:0] objs_per_page(cls_t c);
    return 8'(SLOTS_PER_PAGE >> c);
  endfunction

endpackage

@@ hw/rtl/scsa_if.sv @@
`timescale 1ns / 1ps
interface scsa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] request_size;
  logic [31:0] object_address;
  modport source (output valid, command, request_size, object_address, input ready);
  modport sink   (input valid, command, request_size, object_address, output ready);
endinterface

interface scsa_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] granted_address;
  logic [12:0] object_size;
  logic [2:0]  status;
  modport source (output valid, granted_address, object_size, status, input ready);
  modport sink   (input valid, granted_address, object_size, status, output ready);
endinterface

interface scsa_cfg_if;
  import scsa_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/size_class_slab_allocator.sv @@
// A request transfer is captured, the update state then runs, and its result is loaded into the result register.
// A new request is taken only in the idle state, once the last one is updated; the registered read of the
// tag and link memories comes ahead of the update cycle; a result held by the receiver
// stalls the next update until that result transfers.
// Reset: all control clears at once; the tag memory is then swept to zero, one entry
// a cycle over all POOL_PAGES*128 entries (8192 by default), with request ready held low.
`timescale 1ns / 1ps
`include "size_class_slab_allocator_macros.svh"
module size_class_slab_allocator #(
  parameter int POOL_PAGES = scsa_pkg::POOL_PAGES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  scsa_cfg_if.sink   cfg_i,
  scsa_req_if.sink   req_i,
  scsa_rsp_if.source rsp_o
);
  import scsa_pkg::*;

  localparam int TOTAL_SLOTS = POOL_PAGES * SLOTS_PER_PAGE;
  localparam int SW  = $clog2(TOTAL_SLOTS);
  localparam int LW  = SW + 1;
  localparam int PW  = $clog2(POOL_PAGES + 1);
  localparam int PGW = $clog2(POOL_PAGES);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [SW-1:0]  clr_q;
  logic [31:0]    pool_base_q;
  logic [6:0]     pool_page_limit_q;
  logic [PW-1:0]  pages_taken_q;
  logic [LW-1:0]  free_heads_q [NUM_CLASSES];
  logic [PGW-1:0] fresh_page_q [NUM_CLASSES];
  logic [7:0]     fresh_rem_q  [NUM_CLASSES];

  logic [TAG_W-1:0] tag_mem  [TOTAL_SLOTS];
  logic [LW-1:0]    link_mem [TOTAL_SLOTS];

  logic [1:0]       cmd_q;
  scsa_dec_t        dec, dec_q;
  logic [SW-1:0]    slot, slot_q;
  logic [TAG_W-1:0] tag_rd_q;
  logic [LW-1:0]    link_rd_q;

  logic        rsp_valid_q;
  logic [31:0] rsp_addr_q;
  logic [12:0] rsp_size_q;
  logic [2:0]  rsp_status_q;

  logic in_fire, exec_go;

  // request decode
  scsa_decode #(.POOL_PAGES(POOL_PAGES)) u_decode (
    .request_size_i   (req_i.request_size),
    .object_address_i (req_i.object_address),
    .pool_base_i      (pool_base_q),
    .pages_taken_i    (pages_taken_q),
    .dec_o            (dec),
    .slot_o           (slot)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_fire     = req_i.valid && req_i.ready;
  assign exec_go     = (state_q == S_EXEC) && (!rsp_valid_q || rsp_o.ready);

  // update cycle
  status_e          e_status;
  logic [31:0]      e_addr;
  logic [12:0]      e_size;
  logic             tag_we, link_we, head_we, fresh_we, take_page, grant;
  logic [SW-1:0]    tag_wslot, a_slot;
  logic [TAG_W-1:0] tag_wval;
  cls_t             h_cls;
  logic [LW-1:0]    head_val, head;
  logic [7:0]       rem, new_rem;
  logic             fresh_empty, limit_hit;
  logic [PGW-1:0]   page;
  logic [31:0]      lim;

  always_comb begin
    e_status  = STAT_OK;
    e_addr    = 32'd0;
    e_size    = 13'd0;
    tag_we    = 1'b0;
    link_we   = 1'b0;
    head_we   = 1'b0;
    fresh_we  = 1'b0;
    take_page = 1'b0;
    grant     = 1'b0;
    tag_wslot = '0;
    tag_wval  = '0;
    a_slot    = '0;
    h_cls     = dec_q.cls;
    head_val  = '0;
    head      = free_heads_q[dec_q.cls];
    rem       = fresh_rem_q[dec_q.cls];
    fresh_empty = (rem == 8'd0);
    new_rem   = (fresh_empty ? objs_per_page(dec_q.cls) : rem) - 8'd1;
    page      = fresh_empty ? PGW'(pages_taken_q) : fresh_page_q[dec_q.cls];
    lim       = (32'(pool_page_limit_q) < 32'(POOL_PAGES)) ? 32'(pool_page_limit_q)
                                                            : 32'(POOL_PAGES);
    limit_hit = (32'(pages_taken_q) >= lim);
    unique case (cmd_q)
      CMD_ALLOC: begin
        if (dec_q.zero_size) begin
          e_status = STAT_ZERO_SIZE;
        end else if (dec_q.too_large) begin
          e_status = STAT_TOO_LARGE;
        end else if (head != '0) begin
          a_slot   = SW'(head - LW'(1));
          head_we  = 1'b1;
          head_val = link_rd_q;
          grant    = 1'b1;
        end else if (fresh_empty && limit_hit) begin
          e_status = STAT_NO_PAGE;
        end else begin
          a_slot    = (SW'(page) << SLOT_SHIFT) | (SW'(new_rem) << dec_q.cls);
          fresh_we  = 1'b1;
          take_page = fresh_empty;
          grant     = 1'b1;
        end
        if (grant) begin
          tag_we    = 1'b1;
          tag_wslot = a_slot;
          tag_wval  = {1'b1, dec_q.cls};
          e_addr    = pool_base_q + (32'(a_slot) << MIN_SHIFT) + 32'(HEADER_BYTES);
        end
      end
      CMD_FREE, CMD_QUERY: begin
        h_cls = tag_rd_q[CLS_W-1:0];
        if (dec_q.null_ptr) begin
          e_status = STAT_NULL_PTR;
        end else if (!dec_q.located || !tag_rd_q[TAG_LIVE] ||
                     (4'(tag_rd_q[CLS_W-1:0]) >= 4'(NUM_CLASSES))) begin
          e_status = STAT_BAD_PTR;
        end else if (cmd_q == CMD_FREE) begin
          tag_we    = 1'b1;
          tag_wslot = slot_q;
          link_we   = 1'b1;
          head_we   = 1'b1;
          head_val  = LW'(slot_q) + LW'(1);
        end else begin
          e_size = class_bytes(tag_rd_q[CLS_W-1:0]);
        end
      end
      default: begin
        e_status = STAT_OK;
      end
    endcase
  end

  // tag memory: clearing sweep, then read-modify-write
  always_ff @(posedge clk_i) begin
    if (state_q == S_CLEAR) begin
      tag_mem[clr_q] <= '0;
    end else if (exec_go && tag_we) begin
      tag_mem[tag_wslot] <= tag_wval;
    end
    if (in_fire) begin
      tag_rd_q <= tag_mem[slot];
    end
  end

  // link memory: push on free, read next of the class head on transfer
  always_ff @(posedge clk_i) begin
    if (exec_go && link_we) begin
      link_mem[slot_q] <= free_heads_q[h_cls];
    end
    if (in_fire) begin
      link_rd_q <= link_mem[SW'(free_heads_q[dec.cls] - LW'(1))];
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= req_i.command;
      dec_q  <= dec;
      slot_q <= slot;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_q == SW'(TOTAL_SLOTS - 1)) state_d = S_IDLE;
      S_IDLE:  if (in_fire) state_d = S_EXEC;
      S_EXEC:  if (exec_go) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + SW'(1);
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q       <= 32'd0;
      pool_page_limit_q <= 7'd64;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_POOL_BASE) begin
        pool_base_q <= cfg_i.data;
      end else if (cfg_i.index == CFG_PAGE_LIMIT) begin
        pool_page_limit_q <= cfg_i.data[6:0];
      end
    end
  end

  // class heads, fresh pages and page counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pages_taken_q <= '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        free_heads_q[c] <= '0;
        fresh_page_q[c] <= '0;
        fresh_rem_q[c]  <= '0;
      end
    end else if (exec_go) begin
      if (head_we) begin
        free_heads_q[h_cls] <= head_val;
      end
      if (fresh_we) begin
        fresh_page_q[dec_q.cls] <= page;
        fresh_rem_q[dec_q.cls]  <= new_rem;
      end
      if (take_page) begin
        pages_taken_q <= pages_taken_q + PW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (exec_go) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      rsp_addr_q   <= e_addr;
      rsp_size_q   <= e_size;
      rsp_status_q <= e_status;
    end
  end

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.granted_address = rsp_addr_q;
  assign rsp_o.object_size     = rsp_size_q;
  assign rsp_o.status          = rsp_status_q;

  `SCSA_ASSERT_IMP(a_no_req_in_clear, clk_i, rst_ni, state_q == S_CLEAR, !req_i.ready, "request taken during tag clear")
  `SCSA_ASSERT_NXT(a_fire_to_exec, clk_i, rst_ni, in_fire, state_q == S_EXEC, "transfer not followed by update")
  `SCSA_ASSERT_NXT(a_exec_loads_rsp, clk_i, rst_ni, exec_go, rsp_valid_q, "update did not present a result")
  `SCSA_ASSERT_IMP(a_pages_bound, clk_i, rst_ni, 1'b1, 32'(pages_taken_q) <= 32'(POOL_PAGES), "page counter beyond pool")

endmodule

@@ hw/rtl/scsa_decode.sv @@
`timescale 1ns / 1ps
module scsa_decode #(
  parameter int POOL_PAGES = scsa_pkg::POOL_PAGES_DEF
) (
  input  logic [15:0]                                            request_size_i,
  input  logic [31:0]                                            object_address_i,
  input  logic [31:0]                                            pool_base_i,
  input  logic [$clog2(POOL_PAGES+1)-1:0]                        pages_taken_i,
  output scsa_pkg::scsa_dec_t                                    dec_o,
  output logic [$clog2(POOL_PAGES*scsa_pkg::SLOTS_PER_PAGE)-1:0] slot_o
);
  import scsa_pkg::*;

  localparam int SW = $clog2(POOL_PAGES * SLOTS_PER_PAGE);

  logic [31:0] off;

  // smallest class holding the request
  always_comb begin
    dec_o.cls = cls_t'(NUM_CLASSES - 1);
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (17'(MIN_CLASS_BYTES << c) >= {1'b0, request_size_i}) begin
        dec_o.cls = cls_t'(c);
      end
    end
  end

  assign dec_o.zero_size = (request_size_i == 16'd0);
  assign dec_o.too_large = ({1'b0, request_size_i} > 17'(MAX_REQUEST)) ||
                           ({1'b0, request_size_i} > 17'(MAX_CLASS_BYTES));
  assign dec_o.null_ptr  = (object_address_i == 32'd0);

  // pointer to slot: inside the taken pages and on a slot boundary
  assign off = object_address_i - 32'(HEADER_BYTES) - pool_base_i;
  assign dec_o.located = (off[31:PAGE_SHIFT] < (32-PAGE_SHIFT)'(pages_taken_i)) &&
                         (off[MIN_SHIFT-1:0] == '0);
  assign slot_o = off[SW+MIN_SHIFT-1:MIN_SHIFT];

endmodule

@@ sim/size_class_slab_allocator_test.sv @@
`timescale 1ns / 1ps
module size_class_slab_allocator_test;
  import scsa_pkg::*;

  localparam int LIMIT_CYCLES = 40000;
  localparam int TOTAL_SLOTS  = POOL_PAGES_DEF * SLOTS_PER_PAGE;

  logic clk_i;
  logic rst_ni;

  scsa_cfg_if cfg_if ();
  scsa_req_if req_if ();
  scsa_rsp_if rsp_if ();

  size_class_slab_allocator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if.sink),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  typedef struct packed {
    logic [31:0] addr;
    logic [12:0] size;
    logic [2:0]  status;
  } alloc_result_t;

  // allocator state mirror
  logic [31:0]  pool_base;
  logic [6:0]   page_limit;
  logic [3:0]   slot_tag [TOTAL_SLOTS];
  logic [13:0]  slot_link [TOTAL_SLOTS];
  logic [13:0]  class_head [NUM_CLASSES];
  logic [5:0]   class_page [NUM_CLASSES];
  logic [7:0]   class_left [NUM_CLASSES];
  logic [6:0]   pages_used;

  alloc_result_t pending_results[$];
  logic [31:0]   live_ptrs[$];
  int mismatches;
  int idle_count;
  int send_idle_pct;
  int recv_idle_pct;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [12:0] size_of_class(int c);
    return 13'(MIN_CLASS_BYTES << c);
  endfunction

  function automatic bit find_slot(logic [31:0] ptr, output int slot);
    logic [31:0] off;
    off = ptr - 32'(HEADER_BYTES) - pool_base;
    slot = 0;
    if (64'(off) >= 64'(pages_used) * PAGE_BYTES) return 1'b0;
    if (off % MIN_CLASS_BYTES != 0) return 1'b0;
    slot = int'(off / MIN_CLASS_BYTES);
    return slot < TOTAL_SLOTS;
  endfunction

  // predicts one result and updates the mirror
  function automatic alloc_result_t predict_allocator(logic [1:0] cmd, logic [15:0] req_size,
                                                      logic [31:0] ptr);
    alloc_result_t r;
    int c;
    int slot;
    int lim;
    r = '0;
    if (cmd == CMD_ALLOC) begin
      if (req_size == 0) r.status = STAT_ZERO_SIZE;
      else if (req_size > MAX_REQUEST) r.status = STAT_TOO_LARGE;
      else begin
        c = 0;
        while (size_of_class(c) < req_size) c++;
        if (class_head[c] != 0) begin
          slot = class_head[c] - 1;
          class_head[c] = slot_link[slot];
        end else begin
          if (class_left[c] == 0) begin
            lim = page_limit < POOL_PAGES_DEF ? page_limit : POOL_PAGES_DEF;
            if (pages_used >= lim) begin
              r.status = STAT_NO_PAGE;
              return r;
            end
            class_page[c] = 6'(pages_used);
            class_left[c] = 8'(PAGE_BYTES / size_of_class(c));
            pages_used++;
          end
          class_left[c]--;
          slot = class_page[c] * SLOTS_PER_PAGE + class_left[c] * (size_of_class(c) / 32);
        end
        slot_tag[slot] = 4'(8 | c);
        r.addr = pool_base + 32'(slot) * MIN_CLASS_BYTES + HEADER_BYTES;
      end
    end else if (cmd == CMD_FREE || cmd == CMD_QUERY) begin
      if (ptr == 0) r.status = STAT_NULL_PTR;
      else if (!find_slot(ptr, slot) || !slot_tag[slot][3]) r.status = STAT_BAD_PTR;
      else if (cmd == CMD_QUERY) r.size = size_of_class(slot_tag[slot][2:0]);
      else begin
        c = slot_tag[slot][2:0];
        slot_tag[slot] = '0;
        slot_link[slot] = class_head[c];
        class_head[c] = 14'(slot + 1);
      end
    end
    return r;
  endfunction

  // one request transfer
  task automatic send_request(logic [1:0] cmd, logic [15:0] req_size, logic [31:0] ptr);
    alloc_result_t r;
    do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    req_if.valid          <= 1'b1;
    req_if.command        <= cmd;
    req_if.request_size   <= req_size;
    req_if.object_address <= ptr;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    r = predict_allocator(cmd, req_size, ptr);
    pending_results.push_back(r);
    if (cmd == CMD_ALLOC && r.status == STAT_OK) live_ptrs.push_back(r.addr);
    @(negedge clk_i);
    req_if.valid <= 1'b0;
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    if (idx == CFG_POOL_BASE) pool_base = val;
    else page_limit = val[6:0];
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // frees taken at random from the live list, each optionally after a query
  task automatic free_some_live(int n, bit query_first);
    int k;
    logic [31:0] p;
    for (int i = 0; i < n && live_ptrs.size() != 0; i++) begin
      k = $urandom_range(live_ptrs.size() - 1);
      p = live_ptrs[k];
      live_ptrs.delete(k);
      if (query_first) send_request(CMD_QUERY, '0, p);
      send_request(CMD_FREE, '0, p);
    end
  endtask

  function automatic logic [15:0] random_size();
    int sh;
    sh = $urandom_range(12);
    case ($urandom_range(9))
      0:       return 16'($urandom);
      1:       return 16'(1 << sh);
      2:       return 16'((1 << sh) + 1);
      default: return 16'($urandom_range((32 << $urandom_range(7)), 1));
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] p;
    send_request(CMD_ALLOC, 16'd0, '0);
    send_request(CMD_ALLOC, 16'd4097, '0);
    send_request(CMD_ALLOC, 16'hFFFF, '0);
    send_request(CMD_ALLOC, 16'd1, '0);
    send_request(CMD_ALLOC, 16'd4096, '0);
    send_request(CMD_ALLOC, 16'd33, 32'hFFFF_FFFF);
    send_request(CMD_QUERY, '0, 32'd0);
    send_request(CMD_FREE, '0, 32'd0);
    send_request(CMD_FREE, '0, 32'hFFFF_FFFF);
    send_request(CMD_QUERY, '0, 32'd9);
    p = live_ptrs[0];
    send_request(CMD_QUERY, '0, p);
    send_request(CMD_QUERY, '0, p + 32'd4);
    send_request(CMD_FREE, '0, p);
    send_request(CMD_FREE, '0, p);
    send_request(CMD_QUERY, '0, p);
    send_request(2'd3, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(CMD_ALLOC, 16'd20, '0);
    live_ptrs.delete(0);
    free_some_live(4, 1'b1);
  endtask

  // small pool: drive the allocator out of pages
  task automatic test_exhaustion();
    write_register(CFG_POOL_BASE, 32'hFFFF_F000);
    write_register(CFG_PAGE_LIMIT, 7'd1);
    for (int i = 0; i < 20; i++) send_request(CMD_ALLOC, 16'(1 << $urandom_range(12)), '0);
    free_some_live(6, 1'b0);
    for (int i = 0; i < 6; i++) send_request(CMD_ALLOC, random_size(), '0);
    send_request(CMD_QUERY, '0, 32'h0000_0008);
  endtask

  task automatic test_random(int n);
    logic [31:0] p;
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 45 || live_ptrs.size() == 0) send_request(CMD_ALLOC, random_size(), '0);
      else if (sel < 70) free_some_live(1, 1'b0);
      else if (sel < 82) begin
        p = live_ptrs[$urandom_range(live_ptrs.size() - 1)];
        send_request(CMD_QUERY, '0, p);
      end else if (sel < 88) begin
        p = live_ptrs[$urandom_range(live_ptrs.size() - 1)];
        send_request(CMD_FREE, '0, p + 32'($urandom_range(31)));
      end else send_request(2'($urandom), 16'($urandom), $urandom);
      if (live_ptrs.size() > 150) free_some_live(40, 1'b0);
    end
  endtask

  // result check
  always @(posedge clk_i) begin
    alloc_result_t got;
    alloc_result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = {rsp_if.granted_address, rsp_if.object_size, rsp_if.status};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp addr %h size %0d status %0d, got addr %h size %0d status %0d",
                     want.addr, want.size, want.status, got.addr, got.size, got.status);
        end
      end
    end
  end

  // receiver stall
  always @(negedge clk_i) rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    mismatches    = 0;
    idle_count    = 0;
    send_idle_pct = 13;
    recv_idle_pct = 80;
    pool_base     = '0;
    page_limit    = 7'd64;
    pages_used    = '0;
    for (int i = 0; i < TOTAL_SLOTS; i++) begin
      slot_tag[i]  = '0;
      slot_link[i] = '0;
    end
    for (int c = 0; c < NUM_CLASSES; c++) begin
      class_head[c] = '0;
      class_page[c] = '0;
      class_left[c] = '0;
    end
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.command = '0;
    req_if.request_size = '0;
    req_if.object_address = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    rsp_if.ready = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random(180);
    drain_results();
    test_exhaustion();
    send_idle_pct = 80;
    recv_idle_pct = 13;
    test_random(150);
    drain_results();
    // high base, full pool
    write_register(CFG_POOL_BASE, 32'h5AB0_0000 | $urandom_range(32'hFFFF) << 12);
    write_register(CFG_PAGE_LIMIT, 7'd64);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(200);
    drain_results();
    write_register(CFG_PAGE_LIMIT, 7'd127);
    test_random(60);
    drain_results();

    if (mismatches == 0 && pending_results.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/scsa_pkg.sv
hw/rtl/scsa_if.sv
hw/rtl/scsa_decode.sv
hw/rtl/size_class_slab_allocator.sv
sim/size_class_slab_allocator_test.sv
